// ===== sv/lbmb_pkg.sv =====
// shared constants, codes, command and status types of the linked block message buffer
package lbmb_pkg;

    localparam int POOL_BLOCKS = 32;
    localparam int RING_DEPTH  = 16;
    localparam int BLOCK_BYTES = 8;
    localparam int MAX_CHUNKS  = 32;

    localparam int BLK_W    = $clog2(POOL_BLOCKS);
    localparam int RING_W   = $clog2(RING_DEPTH);
    localparam int FREE_W   = $clog2(POOL_BLOCKS + 1);
    localparam int DATA_W   = 64;
    localparam int LEN_W    = 9;
    localparam int STAT_W   = 3;
    localparam int BSHIFT   = $clog2(BLOCK_BYTES);
    localparam int NEED_W   = LEN_W + 1 - BSHIFT;
    localparam int REM_W    = 6;
    localparam int QC_OUT_W = 4;
    localparam int FB_OUT_W = 6;
    localparam int SUM_W    = ((FREE_W > NEED_W) ? FREE_W : NEED_W) + 1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN = 3'd3;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;
    localparam logic [STAT_W-1:0] ST_READ     = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic                dir;
        logic                store;
        logic                first;
        logic                commit;
        logic [LEN_W-1:0]    len;
        logic                resp_load;
        logic [STAT_W-1:0]   resp_status;
        logic                resp_last;
        logic                rd_desc;
        logic                rd_start;
        logic [NEED_W-1:0]   rd_need;
        logic                rd_issue;
        logic                rd_emit;
        logic                rd_finish;
        logic [LEN_W-1:0]    rem;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0][RING_W-1:0] count;
        logic [1:0][FREE_W-1:0] free;
        logic [LEN_W-1:0]       desc_len;
        logic                   out_free;
    } t_stat;

    // number of blocks a message length needs
    function automatic logic [NEED_W-1:0] need_of(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] sum;
        sum = {1'b0, len} + (LEN_W + 1)'(BLOCK_BYTES - 1);
        return sum[LEN_W:BSHIFT];
    endfunction

endpackage

// ===== sv/lbmb_if.sv =====
// request and result channel interfaces of the linked block message buffer
interface lbmb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic                         direction;
    logic [lbmb_pkg::DATA_W-1:0]  chunk_data;
    logic [lbmb_pkg::LEN_W-1:0]   msg_len;

    modport source (output valid, op, direction, chunk_data, msg_len, input ready);
    modport sink (input valid, op, direction, chunk_data, msg_len, output ready);
endinterface

interface lbmb_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbmb_pkg::STAT_W-1:0]    status;
    logic [lbmb_pkg::DATA_W-1:0]    chunk_data_res;
    logic [lbmb_pkg::LEN_W-1:0]     msg_len_res;
    logic                           last;
    logic [lbmb_pkg::QC_OUT_W-1:0]  queue_count;
    logic [lbmb_pkg::FB_OUT_W-1:0]  free_blocks;

    modport source (output valid, status, chunk_data_res, msg_len_res, last,
                    queue_count, free_blocks, input ready);
    modport sink (input valid, status, chunk_data_res, msg_len_res, last,
                  queue_count, free_blocks, output ready);
endinterface

// ===== sv/lbmb_ctrl.sv =====
// controller state machine: message assembly, checks and read sequencing
module lbmb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbmb_in_if.sink          i_in,
    input  lbmb_pkg::t_stat  i_stat,
    output lbmb_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_WRESP, S_RDESC, S_RISSUE, S_REMIT} t_state;

    t_state                          r_state, n_state;
    logic                            r_active, n_active;
    logic                            r_dropping, n_dropping;
    logic [lbmb_pkg::REM_W-1:0]      r_chunks, n_chunks;
    logic                            r_pend_dir, n_pend_dir;
    logic [lbmb_pkg::LEN_W-1:0]      r_pend_len, n_pend_len;
    logic [lbmb_pkg::STAT_W-1:0]     r_rsp_status, n_rsp_status;
    logic                            r_rsp_last, n_rsp_last;
    logic                            r_rsp_dir, n_rsp_dir;
    logic [lbmb_pkg::LEN_W-1:0]      r_rsp_len, n_rsp_len;
    logic [lbmb_pkg::NEED_W-1:0]     r_rd_left, n_rd_left;
    logic [lbmb_pkg::LEN_W-1:0]      r_rd_rem, n_rd_rem;

    logic [lbmb_pkg::NEED_W-1:0]     w_need;
    logic [lbmb_pkg::NEED_W-1:0]     w_rd_need;
    logic [lbmb_pkg::STAT_W-1:0]     w_first_status;

    // ring-full and length checks on a first chunk, and block count of a read
    always_comb begin
        w_need = lbmb_pkg::need_of(i_in.msg_len);
        w_rd_need = lbmb_pkg::need_of(i_stat.desc_len);
        if (w_rd_need > lbmb_pkg::NEED_W'(lbmb_pkg::MAX_CHUNKS)) begin
            w_rd_need = lbmb_pkg::NEED_W'(lbmb_pkg::MAX_CHUNKS);
        end
        if (i_stat.count[i_in.direction] >= lbmb_pkg::RING_W'(lbmb_pkg::RING_DEPTH - 1)) begin
            w_first_status = lbmb_pkg::ST_FULL;
        end else if (i_in.msg_len == '0) begin
            w_first_status = lbmb_pkg::ST_ZERO_LEN;
        end else if (w_need > lbmb_pkg::NEED_W'(lbmb_pkg::MAX_CHUNKS) ||
                     lbmb_pkg::SUM_W'(w_need) >
                     lbmb_pkg::SUM_W'(i_stat.free[i_in.direction])) begin
            w_first_status = lbmb_pkg::ST_NO_SPACE;
        end else begin
            w_first_status = lbmb_pkg::ST_STORED;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_dropping   = r_dropping;
        n_chunks     = r_chunks;
        n_pend_dir   = r_pend_dir;
        n_pend_len   = r_pend_len;
        n_rsp_status = r_rsp_status;
        n_rsp_last   = r_rsp_last;
        n_rsp_dir    = r_rsp_dir;
        n_rsp_len    = r_rsp_len;
        n_rd_left    = r_rd_left;
        n_rd_rem     = r_rd_rem;
        o_cmd        = '0;
        o_cmd.dir    = r_rsp_dir;
        i_in.ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = i_stat.out_free;
                if (i_in.valid && i_stat.out_free) begin
                    n_state = S_WRESP;
                    if (i_in.op == lbmb_pkg::OP_READ) begin
                        n_rsp_dir = i_in.direction;
                        if (i_stat.count[i_in.direction] == '0) begin
                            n_rsp_status = lbmb_pkg::ST_EMPTY;
                            n_rsp_last   = 1'b0;
                            n_rsp_len    = '0;
                        end else begin
                            o_cmd.rd_desc = 1'b1;
                            o_cmd.dir     = i_in.direction;
                            n_state       = S_RDESC;
                        end
                    end else if (r_active) begin
                        // chunk of an open message
                        n_chunks   = r_chunks - 1'b1;
                        n_rsp_dir  = r_pend_dir;
                        n_rsp_len  = r_pend_len;
                        n_rsp_last = 1'b0;
                        if (r_dropping) begin
                            n_rsp_status = lbmb_pkg::ST_DROPPED;
                            if (n_chunks == '0) begin
                                n_active   = 1'b0;
                                n_dropping = 1'b0;
                            end
                        end else begin
                            n_rsp_status = lbmb_pkg::ST_STORED;
                            o_cmd.store  = 1'b1;
                            o_cmd.dir    = r_pend_dir;
                            o_cmd.len    = r_pend_len;
                            if (n_chunks == '0) begin
                                o_cmd.commit = 1'b1;
                                n_rsp_last   = 1'b1;
                                n_active     = 1'b0;
                            end
                        end
                    end else begin
                        // first chunk of a message
                        n_pend_len   = i_in.msg_len;
                        n_pend_dir   = i_in.direction;
                        n_rsp_dir    = i_in.direction;
                        n_rsp_len    = i_in.msg_len;
                        n_rsp_status = w_first_status;
                        n_rsp_last   = 1'b0;
                        if (w_first_status != lbmb_pkg::ST_STORED) begin
                            if (w_need > lbmb_pkg::NEED_W'(1)) begin
                                n_active   = 1'b1;
                                n_dropping = 1'b1;
                                n_chunks   = lbmb_pkg::REM_W'(w_need - 1'b1);
                            end
                        end else begin
                            o_cmd.store = 1'b1;
                            o_cmd.first = 1'b1;
                            o_cmd.dir   = i_in.direction;
                            o_cmd.len   = i_in.msg_len;
                            if (w_need == lbmb_pkg::NEED_W'(1)) begin
                                o_cmd.commit = 1'b1;
                                n_rsp_last   = 1'b1;
                            end else begin
                                n_active   = 1'b1;
                                n_dropping = 1'b0;
                                n_chunks   = lbmb_pkg::REM_W'(w_need - 1'b1);
                            end
                        end
                    end
                end
            end
            S_WRESP: begin
                o_cmd.resp_load   = 1'b1;
                o_cmd.resp_status = r_rsp_status;
                o_cmd.resp_last   = r_rsp_last;
                o_cmd.len         = r_rsp_len;
                n_state           = S_IDLE;
            end
            S_RDESC: begin
                o_cmd.rd_start = 1'b1;
                o_cmd.rd_need  = w_rd_need;
                n_rd_left      = w_rd_need;
                n_rd_rem       = i_stat.desc_len;
                n_rsp_len      = i_stat.desc_len;
                n_state        = S_RISSUE;
            end
            S_RISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_REMIT;
            end
            S_REMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_emit   = 1'b1;
                    o_cmd.len       = r_rsp_len;
                    o_cmd.rem       = r_rd_rem;
                    o_cmd.resp_last = (r_rd_left == lbmb_pkg::NEED_W'(1));
                    n_rd_left       = r_rd_left - 1'b1;
                    n_rd_rem        = r_rd_rem - lbmb_pkg::LEN_W'(lbmb_pkg::BLOCK_BYTES);
                    if (r_rd_left == lbmb_pkg::NEED_W'(1)) begin
                        o_cmd.rd_finish = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_RISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and assembly registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= 1'b0;
            r_dropping   <= 1'b0;
            r_chunks     <= '0;
            r_pend_dir   <= 1'b0;
            r_pend_len   <= '0;
            r_rsp_status <= lbmb_pkg::ST_STORED;
            r_rsp_last   <= 1'b0;
            r_rsp_dir    <= 1'b0;
            r_rsp_len    <= '0;
            r_rd_left    <= '0;
            r_rd_rem     <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_dropping   <= n_dropping;
            r_chunks     <= n_chunks;
            r_pend_dir   <= n_pend_dir;
            r_pend_len   <= n_pend_len;
            r_rsp_status <= n_rsp_status;
            r_rsp_last   <= n_rsp_last;
            r_rsp_dir    <= n_rsp_dir;
            r_rsp_len    <= n_rsp_len;
            r_rd_left    <= n_rd_left;
            r_rd_rem     <= n_rd_rem;
        end
    end

endmodule

// ===== sv/lbmb_dp.sv =====
// datapath: block pool, links, descriptor rings, counters and result register
module lbmb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbmb_pkg::t_cmd               i_cmd,
    input  logic [lbmb_pkg::DATA_W-1:0]  i_data,
    output lbmb_pkg::t_stat              o_stat,
    lbmb_out_if.source                   o_out
);

    localparam int DESC_W = lbmb_pkg::BLK_W + lbmb_pkg::LEN_W;

    logic [lbmb_pkg::DATA_W-1:0]        r_store [2*lbmb_pkg::POOL_BLOCKS];
    logic [lbmb_pkg::BLK_W-1:0]         r_link  [2*lbmb_pkg::POOL_BLOCKS];
    logic [DESC_W-1:0]                  r_desc  [2*lbmb_pkg::RING_DEPTH];
    logic [1:0][lbmb_pkg::POOL_BLOCKS-1:0] r_in_use;
    logic [1:0][lbmb_pkg::RING_W-1:0]   r_wi;
    logic [1:0][lbmb_pkg::RING_W-1:0]   r_ri;
    logic [1:0][lbmb_pkg::FREE_W-1:0]   r_free;
    logic [lbmb_pkg::BLK_W-1:0]         r_prev;
    logic [lbmb_pkg::BLK_W-1:0]         r_head;
    logic [lbmb_pkg::BLK_W-1:0]         r_blk;
    logic [DESC_W-1:0]                  r_desc_q;
    logic [lbmb_pkg::DATA_W-1:0]        r_data_q;
    logic [lbmb_pkg::BLK_W-1:0]         r_link_q;
    logic [lbmb_pkg::FREE_W-1:0]        r_rfree;
    logic [lbmb_pkg::RING_W-1:0]        r_rqc;
    logic                               r_out_valid;
    logic [lbmb_pkg::STAT_W-1:0]        r_out_status;
    logic [lbmb_pkg::DATA_W-1:0]        r_out_data;
    logic [lbmb_pkg::LEN_W-1:0]         r_out_len;
    logic                               r_out_last;
    logic [lbmb_pkg::RING_W-1:0]        r_out_qc;
    logic [lbmb_pkg::FREE_W-1:0]        r_out_free;

    logic [1:0][lbmb_pkg::RING_W-1:0]   w_count;
    logic [lbmb_pkg::BLK_W-1:0]         w_alloc;
    logic [lbmb_pkg::DATA_W-1:0]        w_masked;
    logic [lbmb_pkg::SUM_W-1:0]         w_rsum;
    logic                               w_out_free;

    // next ring slot
    function automatic logic [lbmb_pkg::RING_W-1:0] ring_inc(
        input logic [lbmb_pkg::RING_W-1:0] idx);
        if (idx == lbmb_pkg::RING_W'(lbmb_pkg::RING_DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    // ring fill per direction
    always_comb begin
        for (int d = 0; d < 2; d++) begin
            if (r_wi[d] >= r_ri[d]) begin
                w_count[d] = r_wi[d] - r_ri[d];
            end else begin
                w_count[d] = lbmb_pkg::RING_W'((lbmb_pkg::RING_W + 1)'(r_wi[d]) +
                             (lbmb_pkg::RING_W + 1)'(lbmb_pkg::RING_DEPTH) -
                             (lbmb_pkg::RING_W + 1)'(r_ri[d]));
            end
        end
    end

    // lowest free block of the addressed direction
    always_comb begin
        w_alloc = '0;
        for (int i = lbmb_pkg::POOL_BLOCKS - 1; i >= 0; i--) begin
            if (!r_in_use[i_cmd.dir][i]) begin
                w_alloc = lbmb_pkg::BLK_W'(i);
            end
        end
    end

    // zero the bytes past the message end
    always_comb begin
        for (int b = 0; b < lbmb_pkg::BLOCK_BYTES; b++) begin
            w_masked[8*b +: 8] = (i_cmd.rem > lbmb_pkg::LEN_W'(b)) ? r_data_q[8*b +: 8] : 8'h00;
        end
    end

    assign w_rsum = lbmb_pkg::SUM_W'(r_free[i_cmd.dir]) + lbmb_pkg::SUM_W'(i_cmd.rd_need);
    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_stat.count    = w_count;
    assign o_stat.free     = r_free;
    assign o_stat.desc_len = r_desc_q[lbmb_pkg::LEN_W-1:0];
    assign o_stat.out_free = w_out_free;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_store[{i_cmd.dir, w_alloc}] <= i_data;
            if (!i_cmd.first) begin
                r_link[{i_cmd.dir, r_prev}] <= w_alloc;
            end
        end
        if (i_cmd.commit) begin
            r_desc[{i_cmd.dir, r_wi[i_cmd.dir]}] <= {(i_cmd.first ? w_alloc : r_head), i_cmd.len};
        end
        if (i_cmd.rd_desc) begin
            r_desc_q <= r_desc[{i_cmd.dir, r_ri[i_cmd.dir]}];
        end
        if (i_cmd.rd_issue) begin
            r_data_q <= r_store[{i_cmd.dir, r_blk}];
            r_link_q <= r_link[{i_cmd.dir, r_blk}];
        end
    end

    // used marks, ring indices and free counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_wi     <= '0;
            r_ri     <= '0;
            for (int d = 0; d < 2; d++) begin
                r_free[d] <= lbmb_pkg::FREE_W'(lbmb_pkg::POOL_BLOCKS);
            end
        end else begin
            if (i_cmd.store) begin
                r_in_use[i_cmd.dir][w_alloc] <= 1'b1;
                if (r_free[i_cmd.dir] != '0) begin
                    r_free[i_cmd.dir] <= r_free[i_cmd.dir] - 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_wi[i_cmd.dir] <= ring_inc(r_wi[i_cmd.dir]);
            end
            if (i_cmd.rd_issue && r_in_use[i_cmd.dir][r_blk]) begin
                r_in_use[i_cmd.dir][r_blk] <= 1'b0;
                if (r_free[i_cmd.dir] < lbmb_pkg::FREE_W'(lbmb_pkg::POOL_BLOCKS)) begin
                    r_free[i_cmd.dir] <= r_free[i_cmd.dir] + 1'b1;
                end
            end
            if (i_cmd.rd_finish) begin
                r_ri[i_cmd.dir] <= ring_inc(r_ri[i_cmd.dir]);
            end
        end
    end

    // chain pointers and read-run counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_prev <= w_alloc;
            if (i_cmd.first) begin
                r_head <= w_alloc;
            end
        end
        if (i_cmd.rd_start) begin
            r_blk <= r_desc_q[DESC_W-1:lbmb_pkg::LEN_W];
            r_rqc <= w_count[i_cmd.dir] - 1'b1;
            if (w_rsum > lbmb_pkg::SUM_W'(lbmb_pkg::POOL_BLOCKS)) begin
                r_rfree <= lbmb_pkg::FREE_W'(lbmb_pkg::POOL_BLOCKS);
            end else begin
                r_rfree <= lbmb_pkg::FREE_W'(w_rsum);
            end
        end
        if (i_cmd.rd_emit) begin
            r_blk <= r_link_q;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_load || i_cmd.rd_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out_status <= i_cmd.resp_status;
            r_out_data   <= '0;
            r_out_len    <= i_cmd.len;
            r_out_last   <= i_cmd.resp_last;
            r_out_qc     <= w_count[i_cmd.dir];
            r_out_free   <= r_free[i_cmd.dir];
        end else if (i_cmd.rd_emit) begin
            r_out_status <= lbmb_pkg::ST_READ;
            r_out_data   <= w_masked;
            r_out_len    <= i_cmd.len;
            r_out_last   <= i_cmd.resp_last;
            r_out_qc     <= r_rqc;
            r_out_free   <= r_rfree;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.chunk_data_res = r_out_data;
    assign o_out.msg_len_res    = r_out_len;
    assign o_out.last           = r_out_last;
    assign o_out.queue_count    = lbmb_pkg::QC_OUT_W'(r_out_qc);
    assign o_out.free_blocks    = lbmb_pkg::FB_OUT_W'(r_out_free);

endmodule

// ===== sv/linked_block_message_buffer_unit.sv =====
// Linked block message buffer: two directions, each a block pool with a descriptor ring.
// Request channel i_in (valid/ready): op 0 writes one 8-byte chunk of a message, the
// first chunk carrying msg_len and direction; op 1 reads the oldest message of a
// direction. Result channel o_out (valid/ready) returns one result per write chunk
// and one result per chunk of a read message, each with queue count and free blocks.
// Write chunk: accepted in S_IDLE, result register loaded from S_WRESP (lowest free block
// found by a priority encoder, block memory and link memory written in the accept cycle).
// Read: a descriptor memory read (S_RDESC), then per chunk a registered block/link memory
// read (S_RISSUE) that must finish before the next link is known, then an emit (S_REMIT).
// A read of an empty ring answers through S_WRESP.
// One request is worked at a time; a new request is taken once the result register
// is empty or being emptied.
// Reset (synchronous, active low) clears used marks, ring indices, assembly state and
// sets both free counts to the pool size; block and descriptor memories keep their
// contents and are only read after being written.
// A stalled receiver holds the result register and the read sequence waits on it.
module linked_block_message_buffer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbmb_in_if.sink     i_in,
    lbmb_out_if.source  o_out
);

    lbmb_pkg::t_cmd  w_cmd;
    lbmb_pkg::t_stat w_stat;

    // control
    lbmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // storage and result register
    lbmb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_data  (i_in.chunk_data),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    // no request taken while a result is stuck
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!o_out.valid || o_out.ready))
        else $error("request taken while result register is blocked");

    // queue count stays within ring capacity
    a_qc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.queue_count <= lbmb_pkg::QC_OUT_W'(lbmb_pkg::RING_DEPTH - 1)))
        else $error("queue count beyond ring capacity");

    // free count never exceeds the pool
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.free_blocks <= lbmb_pkg::FB_OUT_W'(lbmb_pkg::POOL_BLOCKS)))
        else $error("free block count beyond pool size");

    // last only on a commit or a read chunk
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |->
        (o_out.status == lbmb_pkg::ST_STORED || o_out.status == lbmb_pkg::ST_READ))
        else $error("last flag on a non-data result");

    // no read chunk emitted while the result register is blocked
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_emit |-> (!o_out.valid || o_out.ready))
        else $error("read chunk emitted over a pending result");

endmodule

// ===== tb/sv/tb_linked_block_message_buffer_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the linked block message buffer with a built-in predictor
module tb_linked_block_message_buffer_unit;

    typedef struct packed {
        logic [lbmb_pkg::STAT_W-1:0]   status;
        logic [lbmb_pkg::DATA_W-1:0]   data;
        logic [lbmb_pkg::LEN_W-1:0]    len;
        logic                          last;
        logic [lbmb_pkg::QC_OUT_W-1:0] qcount;
        logic [lbmb_pkg::FB_OUT_W-1:0] nfree;
    } t_res;

    typedef struct {
        logic                        op;
        logic                        dir;
        logic [lbmb_pkg::DATA_W-1:0] data;
        logic [lbmb_pkg::LEN_W-1:0]  len;
        bit                          chk;
        logic [lbmb_pkg::STAT_W-1:0] st;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    lbmb_in_if  in_ch ();
    lbmb_out_if out_ch ();

    linked_block_message_buffer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state, one pool and ring per direction
    logic [lbmb_pkg::DATA_W-1:0] pool_data [2][lbmb_pkg::POOL_BLOCKS];
    logic [lbmb_pkg::BLK_W-1:0]  pool_next [2][lbmb_pkg::POOL_BLOCKS];
    bit                          pool_used [2][lbmb_pkg::POOL_BLOCKS];
    logic [lbmb_pkg::BLK_W-1:0]  ring_head [2][lbmb_pkg::RING_DEPTH];
    logic [lbmb_pkg::LEN_W-1:0]  ring_len  [2][lbmb_pkg::RING_DEPTH];
    int                wr_ptr [2];
    int                rd_ptr [2];
    int                free_cnt [2];
    bit                msg_open;
    bit                msg_drop;
    int                chunks_left;
    int                tail_blk;
    int                open_head;
    int                open_len;
    int                open_dir;

    t_res expected_q [$];
    t_row row_check_q [$];
    int   errors = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   hold_request = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int msg_count(int d);
        return (wr_ptr[d] + lbmb_pkg::RING_DEPTH - rd_ptr[d]) % lbmb_pkg::RING_DEPTH;
    endfunction

    function automatic void push_result(int d, logic [lbmb_pkg::STAT_W-1:0] st,
                                        logic [lbmb_pkg::DATA_W-1:0] v, int len, bit last);
        t_res r;
        r.status = st;
        r.data   = v;
        r.len    = lbmb_pkg::LEN_W'(len);
        r.last   = last;
        r.qcount = lbmb_pkg::QC_OUT_W'(msg_count(d));
        r.nfree  = lbmb_pkg::FB_OUT_W'(free_cnt[d]);
        expected_q.push_back(r);
    endfunction

    function automatic void link_chunk(int d, logic [lbmb_pkg::DATA_W-1:0] v, bit first);
        int b;
        b = 0;
        while (pool_used[d][b]) b++;
        pool_data[d][b] = v;
        pool_used[d][b] = 1'b1;
        free_cnt[d]--;
        if (first) open_head = b;
        else pool_next[d][tail_blk] = lbmb_pkg::BLK_W'(b);
        tail_blk = b;
    endfunction

    function automatic void close_message(int d);
        ring_head[d][wr_ptr[d]] = lbmb_pkg::BLK_W'(open_head);
        ring_len[d][wr_ptr[d]]  = lbmb_pkg::LEN_W'(open_len);
        wr_ptr[d] = (wr_ptr[d] + 1) % lbmb_pkg::RING_DEPTH;
        msg_open = 1'b0;
    endfunction

    // expected results of one accepted request
    function automatic void predict_request(logic op, logic dir,
                                            logic [lbmb_pkg::DATA_W-1:0] v,
                                            logic [lbmb_pkg::LEN_W-1:0] len);
        int d, need, b, rem, mlen;
        logic [lbmb_pkg::STAT_W-1:0] st;
        logic [lbmb_pkg::DATA_W-1:0] rv;
        if (op == lbmb_pkg::OP_WRITE && msg_open) begin
            d = open_dir;
            if (chunks_left > 0) chunks_left--;
            if (msg_drop) begin
                if (chunks_left == 0) begin
                    msg_open = 1'b0;
                    msg_drop = 1'b0;
                end
                push_result(d, lbmb_pkg::ST_DROPPED, '0, open_len, 1'b0);
            end else begin
                link_chunk(d, v, 1'b0);
                if (chunks_left == 0) close_message(d);
                push_result(d, lbmb_pkg::ST_STORED, '0, open_len, chunks_left == 0);
            end
        end else if (op == lbmb_pkg::OP_WRITE) begin
            d = int'(dir);
            need = (int'(len) + lbmb_pkg::BLOCK_BYTES - 1) / lbmb_pkg::BLOCK_BYTES;
            st = lbmb_pkg::ST_STORED;
            if (msg_count(d) >= lbmb_pkg::RING_DEPTH - 1) st = lbmb_pkg::ST_FULL;
            else if (len == 0) st = lbmb_pkg::ST_ZERO_LEN;
            else if (need > lbmb_pkg::MAX_CHUNKS || need > free_cnt[d])
                st = lbmb_pkg::ST_NO_SPACE;
            open_len = int'(len);
            open_dir = d;
            if (st != lbmb_pkg::ST_STORED) begin
                if (need > 1) begin
                    msg_open = 1'b1;
                    msg_drop = 1'b1;
                    chunks_left = need - 1;
                end
                push_result(d, st, '0, int'(len), 1'b0);
            end else begin
                link_chunk(d, v, 1'b1);
                if (need == 1) close_message(d);
                else begin
                    msg_open = 1'b1;
                    msg_drop = 1'b0;
                    chunks_left = need - 1;
                end
                push_result(d, lbmb_pkg::ST_STORED, '0, int'(len), need == 1);
            end
        end else begin
            d = int'(dir);
            if (msg_count(d) == 0) begin
                push_result(d, lbmb_pkg::ST_EMPTY, '0, 0, 1'b0);
            end else begin
                mlen = int'(ring_len[d][rd_ptr[d]]);
                b = int'(ring_head[d][rd_ptr[d]]);
                need = (mlen + lbmb_pkg::BLOCK_BYTES - 1) / lbmb_pkg::BLOCK_BYTES;
                rd_ptr[d] = (rd_ptr[d] + 1) % lbmb_pkg::RING_DEPTH;
                // blocks go free as the chain is walked, counts reflect the whole read
                for (int k = 0; k < need; k++) begin
                    if (pool_used[d][b]) begin
                        pool_used[d][b] = 1'b0;
                        free_cnt[d]++;
                    end
                    b = int'(pool_next[d][b]);
                end
                b = int'(ring_head[d][(rd_ptr[d] + lbmb_pkg::RING_DEPTH - 1) %
                                      lbmb_pkg::RING_DEPTH]);
                for (int k = 0; k < need; k++) begin
                    rv = pool_data[d][b];
                    rem = mlen - k * lbmb_pkg::BLOCK_BYTES;
                    if (rem < lbmb_pkg::BLOCK_BYTES) rv &= (64'h1 << (8 * rem)) - 64'h1;
                    push_result(d, lbmb_pkg::ST_READ, rv, mlen, k + 1 == need);
                    b = int'(pool_next[d][b]);
                end
            end
        end
    endfunction

    // request monitor: predict on every accepted request
    always @(negedge i_clk) begin
        t_row row;
        int n0;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n0 = expected_q.size();
            predict_request(in_ch.op, in_ch.direction, in_ch.chunk_data, in_ch.msg_len);
            row = row_check_q.pop_front();
            if (row.chk && expected_q[n0].status != row.st) begin
                errors++;
                if (errors <= 10)
                    $display("table status mismatch: expected %0d predicted %0d",
                             row.st, expected_q[n0].status);
            end
        end
    end

    // result monitor: compare with the oldest expectation
    always @(negedge i_clk) begin
        t_res got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = out_ch.status;
            got.data   = out_ch.chunk_data_res;
            got.len    = out_ch.msg_len_res;
            got.last   = out_ch.last;
            got.qcount = out_ch.queue_count;
            got.nfree  = out_ch.free_blocks;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        int hold_seen, hold_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_request != hold_seen) begin
                hold_seen = hold_request;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // offer one request and wait for acceptance, then maybe go idle
    task automatic send_request(logic op, logic dir, logic [lbmb_pkg::DATA_W-1:0] v,
                                logic [lbmb_pkg::LEN_W-1:0] len, bit chk,
                                logic [lbmb_pkg::STAT_W-1:0] st);
        t_row row;
        bit rdy;
        row.op = op; row.dir = dir; row.data = v; row.len = len; row.chk = chk; row.st = st;
        row_check_q.push_back(row);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.direction  <= dir;
        in_ch.chunk_data <= v;
        in_ch.msg_len    <= len;
        do begin
            @(negedge i_clk);
            rdy = in_ch.ready;
            @(posedge i_clk);
        end while (!rdy);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [lbmb_pkg::DATA_W-1:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    // random message length, mostly short with rare rejects
    function automatic logic [lbmb_pkg::LEN_W-1:0] rand_len(bit short_only);
        int p;
        p = $urandom_range(99);
        if (short_only || p < 70) return lbmb_pkg::LEN_W'($urandom_range(1, 24));
        if (p < 85) return lbmb_pkg::LEN_W'($urandom_range(25, 64));
        if (p < 90) return '0;
        if (p < 95) return lbmb_pkg::LEN_W'($urandom_range(200, 256));
        return lbmb_pkg::LEN_W'($urandom_range(257, 511));
    endfunction

    t_row directed [] = '{
        '{lbmb_pkg::OP_READ,  1'b0, 64'h0,                9'd0,   1'b1, lbmb_pkg::ST_EMPTY},
        '{lbmb_pkg::OP_WRITE, 1'b0, 64'h0123456789abcdef, 9'd0,   1'b1, lbmb_pkg::ST_ZERO_LEN},
        '{lbmb_pkg::OP_WRITE, 1'b1, 64'hffffffffffffffff, 9'd1,   1'b1, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_READ,  1'b1, 64'h0,                9'd0,   1'b1, lbmb_pkg::ST_READ},
        '{lbmb_pkg::OP_WRITE, 1'b0, 64'h5555aaaa5555aaaa, 9'd16,  1'b1, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_READ,  1'b0, 64'h0,                9'd0,   1'b1, lbmb_pkg::ST_EMPTY},
        '{lbmb_pkg::OP_WRITE, 1'b1, 64'haaaa5555aaaa5555, 9'd511, 1'b1, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_READ,  1'b0, 64'h0,                9'd0,   1'b1, lbmb_pkg::ST_READ},
        '{lbmb_pkg::OP_WRITE, 1'b1, 64'hffffffffffffffff, 9'd8,   1'b1, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_WRITE, 1'b0, 64'h0000000000000000, 9'd9,   1'b1, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_WRITE, 1'b1, 64'hffffffffffffffff, 9'd0,   1'b0, lbmb_pkg::ST_STORED},
        '{lbmb_pkg::OP_READ,  1'b0, 64'h0,                9'd0,   1'b0, lbmb_pkg::ST_READ},
        '{lbmb_pkg::OP_READ,  1'b1, 64'h0,                9'd0,   1'b0, lbmb_pkg::ST_READ},
        '{lbmb_pkg::OP_READ,  1'b1, 64'h0,                9'd0,   1'b1, lbmb_pkg::ST_EMPTY},
        '{lbmb_pkg::OP_WRITE, 1'b0, 64'hdeadbeefcafef00d, 9'd256, 1'b1, lbmb_pkg::ST_STORED}
    };

    // main sequence
    initial begin
        int sent, nchunks, phase, wait_cnt;
        bit dir, fill, short_only;
        logic [lbmb_pkg::LEN_W-1:0] len;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= lbmb_pkg::OP_WRITE;
        in_ch.direction  <= 1'b0;
        in_ch.chunk_data <= '0;
        in_ch.msg_len    <= '0;
        wr_ptr = '{0, 0};
        rd_ptr = '{0, 0};
        free_cnt = '{lbmb_pkg::POOL_BLOCKS, lbmb_pkg::POOL_BLOCKS};
        foreach (pool_used[d, b]) pool_used[d][b] = 1'b0;
        msg_open = 1'b0;
        msg_drop = 1'b0;
        chunks_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (directed[i])
            send_request(directed[i].op, directed[i].dir, directed[i].data, directed[i].len,
                         directed[i].chk, directed[i].st);
        // the 256-byte message above needs its remaining 31 chunks
        repeat (31) send_request(lbmb_pkg::OP_WRITE, 1'($urandom_range(1)), rand_data(), '0,
                                 1'b0, lbmb_pkg::ST_STORED);
        send_request(lbmb_pkg::OP_READ, 1'b0, '0, '0, 1'b0, lbmb_pkg::ST_READ);

        // random messages over four idling phases
        sent = 0;
        for (phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 45 : 31) : 0;
            rx_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 45 : 31) : 0;
            if (phase == 0) hold_request++;
            while (sent < 125 * (phase + 1)) begin
                // alternate filling and draining stretches
                fill = ((sent / 40) % 2) == 0;
                short_only = ((sent / 80) % 2) == 1;
                dir = 1'($urandom_range(1));
                if ($urandom_range(99) < (fill ? 12 : 55)) begin
                    send_request(lbmb_pkg::OP_READ, dir, rand_data(),
                                 lbmb_pkg::LEN_W'($urandom), 1'b0, lbmb_pkg::ST_READ);
                    sent++;
                end else begin
                    len = rand_len(short_only);
                    nchunks = (len == 0) ? 1 :
                              (int'(len) + lbmb_pkg::BLOCK_BYTES - 1) / lbmb_pkg::BLOCK_BYTES;
                    for (int c = 0; c < nchunks; c++) begin
                        send_request(lbmb_pkg::OP_WRITE, (c == 0) ? dir : 1'($urandom),
                                     rand_data(),
                                     (c == 0) ? len : lbmb_pkg::LEN_W'($urandom), 1'b0,
                                     lbmb_pkg::ST_STORED);
                        sent++;
                        // a read in the middle of an open message now and then
                        if (c + 1 < nchunks && $urandom_range(99) < 5)
                            send_request(lbmb_pkg::OP_READ, 1'($urandom), '0, '0, 1'b0,
                                         lbmb_pkg::ST_READ);
                    end
                end
            end
        end
        in_ch.valid <= 1'b0;

        // drain
        wait_cnt = 0;
        while (expected_q.size() != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lbmb_pkg.sv
sv/lbmb_if.sv
sv/lbmb_ctrl.sv
sv/lbmb_dp.sv
sv/linked_block_message_buffer_unit.sv
tb/sv/tb_linked_block_message_buffer_unit.sv
